// ===== sv/awam_pkg.sv =====
`timescale 1ns / 1ps

package awam_pkg;

    localparam int TICK_W = 32;
    localparam int LANES  = 4;

    localparam logic [1:0] LANE_X   = 2'd0;
    localparam logic [1:0] LANE_Y   = 2'd1;
    localparam logic [1:0] LANE_Z   = 2'd2;
    localparam logic [1:0] LANE_MAG = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SQRT,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DONE
    } awam_state_t;

endpackage

// ===== sv/awam_ram.sv =====
`timescale 1ns / 1ps

module awam_ram
#(
    parameter int WIDTH = 56,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/accel_window_average_magnitude.sv =====
// A request whose tick repeats skips the squares, the root and the window update and goes
// straight to the divide; a new sample runs through the squares, the bit-pair square root,
// the window update and the divide. One request is taken at a time: a new one is accepted
// only once the result is loaded into the output register and the state machine is idle.
// Reset clears the running sums, the write index, the fill flag and the last tick, so
// the window reads as all zeros; the sample memory itself needs no clearing pass.
`timescale 1ns / 1ps

module accel_window_average_magnitude
    import awam_pkg::*;
#(
    parameter int WINDOW      = 32,
    parameter int SAMPLE_BITS = 14,
    localparam int IN_W  = ((TICK_W + 3 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((4 * SAMPLE_BITS + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // tick_count, accel_x, accel_y, accel_z
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // avg_x, avg_y, avg_z, avg_magnitude
    output logic [OUT_W-1:0] m_axis_tdata,
    // sample_taken
    output logic [0:0]       m_axis_tuser
);

    localparam int S       = SAMPLE_BITS;
    localparam int L       = $clog2(WINDOW);
    localparam int B       = S + L;
    localparam int SUM_W   = B + 1;
    localparam int K       = B + L;
    localparam int SQ_W    = 2 * S;
    localparam int PROD_W  = 2 * B + 1;
    localparam int CNT_W   = $clog2(SAMPLE_BITS);
    localparam int ENTRY_W = LANES * S;
    localparam logic [B:0] RECIP =
        (B + 1)'(((64'd1 << K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    awam_state_t state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [L-1:0]            widx_reg, widx_next;
    logic                    full_reg, full_next;
    logic [TICK_W-1:0]       last_tick_reg, last_tick_next;
    logic                    taken_reg, taken_next;
    logic signed [S-1:0]     samp_reg [3];
    logic signed [S-1:0]     samp_next [3];
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic [SQ_W-1:0]         rem_reg, rem_next;
    logic [SQ_W:0]           root_reg, root_next;
    logic [SQ_W-1:0]         bit_reg, bit_next;
    logic signed [SUM_W-1:0] sum_reg [LANES];
    logic signed [SUM_W-1:0] sum_next [LANES];
    logic [S-1:0]            res_reg [LANES];
    logic [S-1:0]            res_next [LANES];
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]        m_tdata_reg, m_tdata_next;
    logic                    m_tuser_reg, m_tuser_next;

    logic [B-1:0]            mul_a;
    logic [B:0]              mul_b;
    logic [PROD_W-1:0]       mul_p;
    logic [SQ_W:0]           trial;
    logic                    ram_wr_en;
    logic [ENTRY_W-1:0]      ram_wr_data;
    logic [ENTRY_W-1:0]      ram_rd_data;
    logic signed [S-1:0]     sel_samp;
    logic [B-1:0]            samp_ext;
    logic signed [SUM_W-1:0] sel_sum;
    logic [SUM_W-1:0]        sum_abs;
    logic [S-1:0]            quot;
    logic [S-1:0]            new_lane;
    logic [S-1:0]            old_lane;
    logic [SUM_W-1:0]        new_ext;
    logic [SUM_W-1:0]        old_ext;
    logic                    s_accept;
    logic                    out_free;

    awam_ram
    #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW)
    )
    u_ram
    (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (widx_reg),
        .wr_data (ram_wr_data),
        .rd_addr (widx_reg),
        .rd_data (ram_rd_data)
    );

    assign sel_samp = samp_reg[cnt_reg[1:0] == LANE_X ? 0 : (cnt_reg[1:0] == LANE_Y ? 1 : 2)];
    assign samp_ext = {{L{sel_samp[S-1]}}, sel_samp};
    assign sel_sum  = sum_reg[cnt_reg[1:0]];
    assign sum_abs  = sel_sum[SUM_W-1] ? (~sel_sum + 1'b1) : sel_sum;
    assign mul_a    = (state_reg == ST_SQUARE)
                    ? (sel_samp[S-1] ? (~samp_ext + 1'b1) : samp_ext)
                    : sum_abs[B-1:0];
    assign mul_b    = (state_reg == ST_SQUARE) ? {1'b0, mul_a} : RECIP;
    assign mul_p    = {{(B + 1){1'b0}}, mul_a} * {{B{1'b0}}, mul_b};
    assign quot     = mul_p[K +: S];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_tvalid_reg || m_axis_tready;
    assign ram_wr_en     = (state_reg == ST_UPDATE);
    assign ram_wr_data   = {root_reg[S-1:0], samp_reg[2], samp_reg[1], samp_reg[0]};
    assign trial         = root_reg + {1'b0, bit_reg};

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            widx_reg      <= '0;
            full_reg      <= 1'b0;
            last_tick_reg <= '0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < LANES; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            widx_reg      <= widx_next;
            full_reg      <= full_next;
            last_tick_reg <= last_tick_next;
            m_tvalid_reg  <= m_tvalid_next;
            for (int i = 0; i < LANES; i++)
            begin
                sum_reg[i] <= sum_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        taken_reg   <= taken_next;
        sq_reg      <= sq_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        bit_reg     <= bit_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        for (int i = 0; i < 3; i++)
        begin
            samp_reg[i] <= samp_next[i];
        end
        for (int i = 0; i < LANES; i++)
        begin
            res_reg[i] <= res_next[i];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        widx_next      = widx_reg;
        full_next      = full_reg;
        last_tick_next = last_tick_reg;
        taken_next     = taken_reg;
        sq_next        = sq_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        m_tvalid_next  = m_tvalid_reg && !m_axis_tready;
        for (int i = 0; i < 3; i++)
        begin
            samp_next[i] = samp_reg[i];
        end
        for (int i = 0; i < LANES; i++)
        begin
            sum_next[i] = sum_reg[i];
            res_next[i] = res_reg[i];
        end

        new_lane = '0;
        old_lane = '0;
        new_ext  = '0;
        old_ext  = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    samp_next[0] = s_axis_tdata[TICK_W +: S];
                    samp_next[1] = s_axis_tdata[TICK_W + S +: S];
                    samp_next[2] = s_axis_tdata[TICK_W + 2 * S +: S];
                    sq_next      = '0;
                    cnt_next     = '0;
                    if (s_axis_tdata[TICK_W-1:0] != last_tick_reg)
                    begin
                        taken_next     = 1'b1;
                        last_tick_next = s_axis_tdata[TICK_W-1:0];
                        state_next     = ST_SQUARE;
                    end
                    else
                    begin
                        taken_next = 1'b0;
                        state_next = ST_DIVIDE;
                    end
                end
            end

            ST_SQUARE:
            begin
                sq_next = sq_reg + mul_p[SQ_W-1:0];
                if (cnt_reg[1:0] == LANE_Z)
                begin
                    rem_next   = sq_next;
                    root_next  = '0;
                    bit_next   = SQ_W'(1) << (SQ_W - 2);
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_SQRT:
            begin
                if ({1'b0, rem_reg} >= trial)
                begin
                    rem_next  = rem_reg - trial[SQ_W-1:0];
                    root_next = (root_reg >> 1) + {1'b0, bit_reg};
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (cnt_reg == CNT_W'(S - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_UPDATE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_UPDATE:
            begin
                // An entry not yet written since reset counts as zero.
                for (int i = 0; i < LANES; i++)
                begin
                    new_lane = ram_wr_data[i * S +: S];
                    old_lane = full_reg ? ram_rd_data[i * S +: S] : '0;
                    if (i == int'(LANE_MAG))
                    begin
                        new_ext = {{(SUM_W - S){1'b0}}, new_lane};
                        old_ext = {{(SUM_W - S){1'b0}}, old_lane};
                    end
                    else
                    begin
                        new_ext = {{(SUM_W - S){new_lane[S-1]}}, new_lane};
                        old_ext = {{(SUM_W - S){old_lane[S-1]}}, old_lane};
                    end
                    sum_next[i] = sum_reg[i] + new_ext - old_ext;
                end
                if (widx_reg == L'(WINDOW - 1))
                begin
                    widx_next = '0;
                    full_next = 1'b1;
                end
                else
                begin
                    widx_next = widx_reg + 1'b1;
                end
                cnt_next   = '0;
                state_next = ST_DIVIDE;
            end

            ST_DIVIDE:
            begin
                res_next[cnt_reg[1:0]] = sel_sum[SUM_W-1] ? (~quot + 1'b1) : quot;
                if (cnt_reg[1:0] == LANE_MAG)
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tdata_next  = OUT_W'({res_reg[3], res_reg[2], res_reg[1], res_reg[0]});
                    m_tuser_next  = taken_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import awam_pkg::*;

    localparam int SB  = 14;
    localparam int WIN = 32;
    localparam int IN_W  = ((TICK_W + 3 * SB + 7) / 8) * 8;
    localparam int OUT_W = ((4 * SB + 7) / 8) * 8;

    typedef struct {
        logic signed [SB-1:0] avg_x;
        logic signed [SB-1:0] avg_y;
        logic signed [SB-1:0] avg_z;
        logic [SB-1:0]        avg_mag;
        logic                 taken;
    } window_avg_t;

    class window_scoreboard;
        logic signed [SB-1:0] x_hist [WIN];
        logic signed [SB-1:0] y_hist [WIN];
        logic signed [SB-1:0] z_hist [WIN];
        logic [SB-1:0]        mag_hist [WIN];
        logic [4:0]           slot;
        logic [TICK_W-1:0]    prev_tick;
        window_avg_t          awaited [$];
        int                   errors;

        function new();
            for (int i = 0; i < WIN; i++)
            begin
                x_hist[i] = '0;
                y_hist[i] = '0;
                z_hist[i] = '0;
                mag_hist[i] = '0;
            end
            slot = '0;
            prev_tick = '0;
            errors = 0;
        endfunction

        function int unsigned floor_root(longint unsigned n);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int b = 15; b >= 0; b--)
            begin
                t = r | (64'd1 << b);
                if (t * t <= n)
                    r = t;
            end
            return int'(r);
        endfunction

        function void note_request(logic [TICK_W-1:0] tick, logic signed [SB-1:0] x,
                                   logic signed [SB-1:0] y, logic signed [SB-1:0] z);
            window_avg_t     e;
            longint          sq;
            int              sx;
            int              sy;
            int              sz;
            int unsigned     sm;
            int unsigned     root;
            e.taken = (tick != prev_tick);
            if (e.taken)
            begin
                sq = longint'(x) * longint'(x) + longint'(y) * longint'(y)
                   + longint'(z) * longint'(z);
                root = floor_root(longint'(sq));
                x_hist[slot] = x;
                y_hist[slot] = y;
                z_hist[slot] = z;
                mag_hist[slot] = root[SB-1:0];
                slot = slot + 5'd1;
                prev_tick = tick;
            end
            sx = 0;
            sy = 0;
            sz = 0;
            sm = 0;
            for (int i = 0; i < WIN; i++)
            begin
                sx += int'(x_hist[i]);
                sy += int'(y_hist[i]);
                sz += int'(z_hist[i]);
                sm += int'(mag_hist[i]);
            end
            sx = sx / WIN;
            sy = sy / WIN;
            sz = sz / WIN;
            sm = sm / WIN;
            e.avg_x = sx[SB-1:0];
            e.avg_y = sy[SB-1:0];
            e.avg_z = sz[SB-1:0];
            e.avg_mag = sm[SB-1:0];
            awaited.push_back(e);
        endfunction

        function void check_result(logic [OUT_W-1:0] data, logic [0:0] user);
            window_avg_t          e;
            logic signed [SB-1:0] ax;
            logic signed [SB-1:0] ay;
            logic signed [SB-1:0] az;
            logic [SB-1:0]        am;
            ax = data[SB-1:0];
            ay = data[2*SB-1:SB];
            az = data[3*SB-1:2*SB];
            am = data[4*SB-1:3*SB];
            if (awaited.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (ax !== e.avg_x)
            begin
                $error("avg_x: expected %0d, got %0d", e.avg_x, ax);
                errors++;
            end
            if (ay !== e.avg_y)
            begin
                $error("avg_y: expected %0d, got %0d", e.avg_y, ay);
                errors++;
            end
            if (az !== e.avg_z)
            begin
                $error("avg_z: expected %0d, got %0d", e.avg_z, az);
                errors++;
            end
            if (am !== e.avg_mag)
            begin
                $error("avg_magnitude: expected %0d, got %0d", e.avg_mag, am);
                errors++;
            end
            if (user[0] !== e.taken)
            begin
                $error("sample_taken: expected %0d, got %0d", e.taken, user[0]);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic [0:0]        m_axis_tuser;

    window_scoreboard  sb;
    bit                quiet;
    logic [TICK_W-1:0] drv_tick;

    accel_window_average_magnitude u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("accel_window_average_magnitude test failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_request(input logic [TICK_W-1:0] tick, input logic [SB-1:0] x,
                                input logic [SB-1:0] y, input logic [SB-1:0] z);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_W - TICK_W - 3 * SB){1'b0}}, z, y, x, tick};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(tick, x, y, z);
        drv_tick = tick;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_random(input int count);
        int                mode;
        int                run_left;
        int                r;
        logic [TICK_W-1:0] tick;
        logic [SB-1:0]     x;
        logic [SB-1:0]     y;
        logic [SB-1:0]     z;
        mode = 0;
        run_left = 0;
        for (int n = 0; n < count; n++)
        begin
            quiet = (n >= 250 && n < 350);
            if (run_left == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    mode = 0;
                    run_left = $urandom_range(20, 60);
                end
                else if (r < 75)
                begin
                    mode = 1;
                    run_left = $urandom_range(34, 40);
                end
                else if (r < 90)
                begin
                    mode = 2;
                    run_left = $urandom_range(34, 40);
                end
                else
                begin
                    mode = 3;
                    run_left = $urandom_range(20, 40);
                end
            end
            run_left--;
            r = $urandom_range(0, 99);
            if (r < 80)
                tick = drv_tick + 32'd1;
            else if (r < 92)
                tick = drv_tick;
            else if (r < 95)
                tick = '0;
            else
                tick = $urandom;
            case (mode)
                1:
                begin
                    x = 14'h1fff;
                    y = 14'h1fff;
                    z = 14'h1fff;
                end
                2:
                begin
                    x = 14'h2000;
                    y = 14'h2000;
                    z = 14'h2000;
                end
                3:
                begin
                    x = 14'($signed($urandom_range(0, 6)) - 3);
                    y = 14'($signed($urandom_range(0, 6)) - 3);
                    z = 14'($signed($urandom_range(0, 6)) - 3);
                end
                default:
                begin
                    x = SB'($urandom_range(0, 16383));
                    y = SB'($urandom_range(0, 16383));
                    z = SB'($urandom_range(0, 16383));
                end
            endcase
            send_request(tick, x, y, z);
        end
    endtask

    initial
    begin
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    initial
    begin
        int waited;
        sb = new();
        quiet = 1'b0;
        drv_tick = '0;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first request carries tick zero and so counts as a repeat.
        send_request(32'd0, 14'd1234, 14'h3c00, 14'd77);
        send_request(32'd1, 14'h1fff, 14'h1fff, 14'h1fff);
        send_request(32'd1, 14'h2000, 14'h0001, 14'h3fff);
        send_request(32'd2, 14'h2000, 14'h2000, 14'h2000);
        send_request(32'hffff_ffff, 14'd0, 14'd0, 14'd0);
        send_request(32'd0, 14'h3fff, 14'h3fff, 14'h3fff);
        send_request(32'd0, 14'd5, 14'd5, 14'd5);
        send_request(32'h8000_0000, 14'h1fff, 14'h2000, 14'd0);
        send_request(32'h7fff_ffff, 14'h2000, 14'h1fff, 14'h3fff);
        send_request(32'h5555_5555, 14'd1, 14'd0, 14'd0);
        send_request(32'haaaa_aaaa, 14'd0, 14'h3fff, 14'd0);
        send_request(32'h0000_0003, 14'd0, 14'd0, 14'h1fff);
        send_request(32'h0000_0004, 14'd3, 14'd4, 14'd12);
        send_request(32'h0000_0004, 14'd3, 14'd4, 14'd12);
        send_request(32'h1234_5678, 14'h2aaa, 14'h1555, 14'h2aaa);
        send_request(32'h1234_5679, 14'h1555, 14'h2aaa, 14'h1555);

        run_random(650);
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        waited = 0;
        while (waited < 40)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.errors == 0 && sb.pending() == 0)
            $display("accel_window_average_magnitude test passed");
        else
            $display("accel_window_average_magnitude test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/awam_pkg.sv
sv/awam_ram.sv
sv/accel_window_average_magnitude.sv
sim/tb.sv
